>>> src/signed_to_decimal_ascii_core_assert.svh
// Assertion macros used by s2da_emit, the character stage of the decimal text converter.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef SIGNED_TO_DECIMAL_ASCII_CORE_ASSERT_SVH
`define SIGNED_TO_DECIMAL_ASCII_CORE_ASSERT_SVH

// Check a condition in the same cycle as its trigger.
`define S2DA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Check a condition in the cycle after its trigger.
`define S2DA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> src/s2da_pkg.sv
package s2da_pkg;

	// Operand and text geometry
	localparam int VALW  = 64;
	localparam int NDIG  = 19;
	localparam int DIGW  = 4;
	localparam int CHARW = 8;
	localparam int CNTW  = $clog2(VALW);
	localparam int NDW   = $clog2(NDIG + 1);
	localparam int IDXW  = $clog2(NDIG);

	// Character codes
	localparam logic [CHARW-1:0] ASCII_ZERO  = 8'd48;
	localparam logic [CHARW-1:0] ASCII_MINUS = 8'd45;

	// Decimal digits, least significant in entry 0
	typedef logic [NDIG-1:0][DIGW-1:0] bcd_t;

	// Converted number handed from the converter to the character stage
	typedef struct packed {
		bcd_t           bcd;
		logic [NDW-1:0] nd;
		logic           neg;
	} num_t;

	// Correct one digit before it doubles: 5..9 gain 3
	function automatic logic [DIGW-1:0] dabble_fix(input logic [DIGW-1:0] d);
		logic [DIGW-1:0] r;
		r = (d >= DIGW'(5)) ? DIGW'(d + DIGW'(3)) : d;
		return r;
	endfunction

endpackage

>>> src/s2da_dabble.sv
module s2da_dabble import s2da_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [VALW-1:0] value,
	output logic            num_valid,
	input  logic            num_ready,
	output num_t            num
);

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_RUN  = 3'b010,
		C_DONE = 3'b100
	} cstate_t;

	cstate_t               state_q;
	logic [VALW-1:0]       mag_q;
	bcd_t                  bcd_q;
	logic [NDW-1:0]        nd_q;
	logic                  neg_q;
	logic [CNTW-1:0]       cnt_q;

	logic [NDIG*DIGW-1:0]  fix_flat;
	bcd_t                  bcd_nxt;
	logic                  grow;

	// Correct every digit, then shift the next magnitude bit in
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			fix_flat[i*DIGW +: DIGW] = dabble_fix(bcd_q[i]);
		end
		bcd_nxt = bcd_t'({fix_flat[NDIG*DIGW-2:0], mag_q[VALW-1]});
	end

	// The top digit can move up by at most one place per step
	assign grow = (nd_q < NDW'(NDIG)) && (bcd_nxt[nd_q[IDXW-1:0]] != '0);

	assign in_ready  = (state_q == C_IDLE);
	assign num_valid = (state_q == C_DONE);
	assign num       = '{bcd: bcd_q, nd: nd_q, neg: neg_q};

	// Sequence: load, 64 shift steps, hold until handed off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
			nd_q    <= NDW'(1);
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (in_valid) begin
						state_q <= C_RUN;
						cnt_q   <= '0;
						nd_q    <= NDW'(1);
					end
				end
				C_RUN: begin
					cnt_q <= CNTW'(cnt_q + CNTW'(1));
					if (grow) begin
						nd_q <= NDW'(nd_q + NDW'(1));
					end
					if (cnt_q == CNTW'(VALW - 1)) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (num_ready) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Magnitude and digit shift registers
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && in_valid) begin
			neg_q <= value[VALW-1];
			mag_q <= value[VALW-1] ? VALW'(~value + VALW'(1)) : value;
			bcd_q <= '0;
		end else if (state_q == C_RUN) begin
			mag_q <= {mag_q[VALW-2:0], 1'b0};
			bcd_q <= bcd_nxt;
		end
	end

endmodule

>>> src/s2da_emit.sv
`include "signed_to_decimal_ascii_core_assert.svh"

module s2da_emit import s2da_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             num_valid,
	output logic             num_ready,
	input  num_t             num,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [CHARW-1:0] m_tdata,
	output logic             m_tlast
);

	typedef enum logic [2:0] {
		E_IDLE  = 3'b001,
		E_SIGN  = 3'b010,
		E_DIGIT = 3'b100
	} estate_t;

	estate_t          state_q;
	logic [IDXW-1:0]  idx_q;
	logic             tvalid_q;
	bcd_t             bcd_q;
	logic [CHARW-1:0] chr_q;
	logic             last_q;

	logic             load;
	logic             advance;
	logic             char_ok;

	assign num_ready = (state_q == E_IDLE);
	assign load      = num_valid && num_ready;
	// Produce a word whenever the output register is free or being drained
	assign advance   = (state_q != E_IDLE) && (!tvalid_q || m_tready);

	assign m_tvalid = tvalid_q;
	assign m_tdata  = chr_q;
	assign m_tlast  = last_q;

	// Outgoing word is a minus sign or a decimal digit
	assign char_ok = (m_tdata == ASCII_MINUS) ||
	                 (m_tdata >= ASCII_ZERO && m_tdata <= CHARW'(ASCII_ZERO + CHARW'(9)));

	// Walk the sign, then the digits from the top one down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			idx_q    <= '0;
			tvalid_q <= 1'b0;
		end else begin
			if (advance) begin
				tvalid_q <= 1'b1;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
			unique case (state_q)
				E_IDLE: begin
					if (load) begin
						state_q <= num.neg ? E_SIGN : E_DIGIT;
						idx_q   <= IDXW'(num.nd - NDW'(1));
					end
				end
				E_SIGN: begin
					if (advance) begin
						state_q <= E_DIGIT;
					end
				end
				E_DIGIT: begin
					if (advance) begin
						if (idx_q == '0) begin
							state_q <= E_IDLE;
						end else begin
							idx_q <= IDXW'(idx_q - IDXW'(1));
						end
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

	// Hold the digits and build the outgoing word
	always_ff @(posedge clk) begin
		if (load) begin
			bcd_q <= num.bcd;
		end
		if (advance) begin
			chr_q  <= (state_q == E_SIGN) ? ASCII_MINUS
			                              : CHARW'(ASCII_ZERO + CHARW'(bcd_q[idx_q]));
			last_q <= (state_q == E_DIGIT) && (idx_q == '0);
		end
	end

	`S2DA_ASSERT_IMP(a_sign_not_last, m_tvalid && m_tdata == ASCII_MINUS, !m_tlast)
	`S2DA_ASSERT_IMP(a_char_code, m_tvalid, char_ok)
	`S2DA_ASSERT_NXT(a_load_starts, load, state_q == E_SIGN || state_q == E_DIGIT)
	`S2DA_ASSERT_IMP(a_idx_range, state_q == E_DIGIT, idx_q < IDXW'(NDIG))

endmodule

>>> src/signed_to_decimal_ascii_core.sv
// Signed 64-bit integer to decimal ASCII text. Each word taken on the s_ side is
// one two's complement value; the m_ side returns its text one character per
// word, most significant digit first, with a leading '-' for negative values
// and tlast on the final digit (zero gives the single character '0'). The
// conversion shifts the magnitude one bit per cycle into a 19-digit BCD
// register; a value is loaded, shifted through all 64 bits whatever its size,
// then handed off. The converted digits move to a separate character stage,
// so the next value converts while the previous text goes out at one character
// per cycle (up to 20) while the sink does not stall; a new value is accepted
// once the previous one has been handed to the character stage.
module signed_to_decimal_ascii_core import s2da_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [VALW-1:0]  s_tdata,   // [63:0] value
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [CHARW-1:0] m_tdata,   // [7:0] text_char
	output logic             m_tlast
);

	logic num_valid;
	logic num_ready;
	num_t num;

	// Binary to BCD by shift and correct
	s2da_dabble u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.value     (s_tdata),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num       (num)
	);

	// Sign and digit characters out
	s2da_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.num       (num),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

>>> verif/testbench.sv
module testbench;
	import s2da_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 100;
	localparam int REPORT_MAX   = 10;
	localparam int PHASE_ITEMS  = 107;

	// One expected character of the decimal text
	typedef struct packed {
		logic [CHARW-1:0] ch;
		logic             last;
	} text_word_t;

	// Predicts the text of each accepted value and checks the returned characters
	class decimal_text_board;
		text_word_t expected_text[$];
		int         mismatches;

		function new();
			mismatches = 0;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_MAX) begin
				$display("%s", msg);
			end
		endfunction

		// Build the expected characters: optional sign, then digits high to low
		function void note_value(logic [VALW-1:0] value);
			logic [VALW-1:0] mag;
			logic [DIGW-1:0] digits[$];
			text_word_t      w;
			mag = value[VALW-1] ? VALW'(-value) : value;
			do begin
				digits.push_front(DIGW'(mag % VALW'(10)));
				mag = mag / VALW'(10);
			end while (mag != '0);
			if (value[VALW-1]) begin
				w.ch = ASCII_MINUS;
				w.last = 1'b0;
				expected_text.push_back(w);
			end
			foreach (digits[i]) begin
				w.ch = ASCII_ZERO + CHARW'(digits[i]);
				w.last = (i == digits.size() - 1);
				expected_text.push_back(w);
			end
		endfunction

		// Compare one returned character with the oldest expectation
		function void check_char(logic [CHARW-1:0] ch, logic last);
			text_word_t want;
			if (expected_text.size() == 0) begin
				flag($sformatf("unexpected char %0d last %0b with nothing pending", ch, last));
				return;
			end
			want = expected_text.pop_front();
			if (ch !== want.ch || last !== want.last) begin
				flag($sformatf("char mismatch: expected %0d last %0b, got %0d last %0b",
					want.ch, want.last, ch, last));
			end
		endfunction

		function int pending();
			return expected_text.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [VALW-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [CHARW-1:0] m_tdata;
	logic             m_tlast;

	decimal_text_board board;
	int                send_idle_pct;
	int                sink_stall_pct;
	int                cycles = 0;

	signed_to_decimal_ascii_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// Stall the sink at random
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Check every character word taken from the block
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_char(m_tdata, m_tlast);
		end
	end

	function automatic logic [VALW-1:0] ten_pow(int k);
		logic [VALW-1:0] p;
		p = 1;
		repeat (k) p = p * VALW'(10);
		return p;
	endfunction

	// Mix full-range values, short numbers and digit-count boundaries
	function automatic logic [VALW-1:0] random_value();
		logic [VALW-1:0] v;
		int              k;
		case ($urandom_range(3))
			0: v = {$urandom, $urandom};
			1: v = VALW'($urandom_range(999));
			2: begin
				k = $urandom_range(1, 19);
				v = {$urandom, $urandom} % ten_pow(k);
			end
			default: begin
				k = $urandom_range(19);
				case ($urandom_range(3))
					0: v = ten_pow(k);
					1: v = ten_pow(k) - 1;
					2: v = {1'b0, {(VALW-1){1'b1}}} - VALW'($urandom_range(3));
					default: v = {1'b1, {(VALW-1){1'b0}}} + VALW'($urandom_range(3));
				endcase
			end
		endcase
		if ($urandom_range(1)) begin
			v = -v;
		end
		return v;
	endfunction

	// Offer one value, hold until taken, then idle at random
	task automatic push_value(input logic [VALW-1:0] value);
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		board.note_value(value);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold the sender until all pending text has come back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	initial begin
		logic [VALW-1:0] directed[$];
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		send_idle_pct = 0;
		sink_stall_pct = 0;

		directed = '{
			64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
			-64'd100, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
			64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
			64'd999999999999999999, 64'd1000000000000000000, -64'd1000000000000000000,
			64'd1234567890123456789, -64'd1234567890123456789,
			64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes and boundaries with no idling
		foreach (directed[i]) begin
			push_value(directed[i]);
		end

		// Random values under each idling mix; drain between mixes
		for (int phase = 0; phase < 4; phase++) begin
			hold_until_drained();
			case (phase)
				0: begin
					send_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 72;
					sink_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					sink_stall_pct = 72;
				end
				default: begin
					send_idle_pct = 17;
					sink_stall_pct = 17;
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				push_value(random_value());
			end
		end

		hold_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
